// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("invariant violated");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication violated");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// shared codes and types of the bounded deque
// ----------------------------------------------------------------------------
package bdq_pkg;

  // command codes
  localparam logic [2:0] CMD_PUSH_TAIL = 3'd0;
  localparam logic [2:0] CMD_PUSH_HEAD = 3'd1;
  localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
  localparam logic [2:0] CMD_POP_TAIL  = 3'd3;
  localparam logic [2:0] CMD_DELETE    = 3'd4;

  // status codes
  localparam logic [1:0] STS_DONE      = 2'd0;
  localparam logic [1:0] STS_EMPTY     = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;
  localparam logic [1:0] STS_NOT_FOUND = 2'd3;

  // fixed field widths of the stream
  localparam int CMD_W   = 3;
  localparam int ITEM_W  = 32;
  localparam int STS_W   = 2;
  localparam int IN_W    = ((CMD_W + ITEM_W + 7) / 8) * 8;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // result strobe from the engine
  typedef struct packed {
    logic             valid;
    logic [STS_W-1:0] status;
  } res_ctl_t;

endpackage

// ===== hw/rtl/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/bdq_engine.sv =====
// ----------------------------------------------------------------------------
// bdq_engine
// head/count bookkeeping, push/pop updates and the delete compaction scan
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdq_engine #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32,
  localparam int IDX_W      = $clog2(CAPACITY),
  localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   req_valid,
  input  logic [2:0]             req_cmd,
  input  logic [VALUE_WIDTH-1:0] req_value,
  output logic                   req_ready,
  output bdq_pkg::res_ctl_t      res,
  output logic [CNT_W-1:0]       res_removed,
  output logic [CNT_W-1:0]       res_length
);

  import bdq_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  // physical slot of a logical offset from the head
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic [CNT_W-1:0]       rd_off_r, rd_off_nxt;
  logic [CNT_W-1:0]       kept_r, kept_nxt;
  logic                   rd_vld_r, rd_vld_nxt;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic                   rd_issue;
  logic [IDX_W-1:0]       rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   scan_done;
  logic                   is_full;
  logic                   is_empty;

  bdq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign is_full   = (count_r == CAP_CNT);
  assign is_empty  = (count_r == '0);
  assign req_ready = (state_r == ST_IDLE);
  assign rd_issue  = (state_r == ST_SCAN) && (rd_off_r != count_r);
  assign rd_addr   = wrap_add(head_r, rd_off_r);
  assign scan_done = (state_r == ST_SCAN) && (rd_off_r == count_r) && !rd_vld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req_valid && (req_cmd == CMD_DELETE) && !is_empty) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    value_nxt   = value_r;
    rd_off_nxt  = rd_off_r;
    kept_nxt    = kept_r;
    rd_vld_nxt  = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = wrap_add(head_r, count_r);
    wr_data     = req_value;
    res         = '0;
    res_removed = '0;
    res_length  = count_r;

    if (state_r == ST_IDLE) begin
      if (req_valid) begin
        res.valid  = 1'b1;
        res.status = STS_DONE;
        case (req_cmd)
          CMD_PUSH_TAIL: begin
            if (is_full) begin
              res.status = STS_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          CMD_PUSH_HEAD: begin
            if (is_full) begin
              res.status = STS_FULL;
            end else begin
              head_nxt  = (head_r == '0) ? LAST_IDX : head_r - IDX_W'(1);
              wr_en     = 1'b1;
              wr_addr   = head_nxt;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          CMD_POP_HEAD: begin
            if (is_empty) begin
              res.status = STS_EMPTY;
            end else begin
              head_nxt    = wrap_add(head_r, CNT_W'(1));
              count_nxt   = count_r - CNT_W'(1);
              res_removed = CNT_W'(1);
            end
          end
          CMD_POP_TAIL: begin
            if (is_empty) begin
              res.status = STS_EMPTY;
            end else begin
              count_nxt   = count_r - CNT_W'(1);
              res_removed = CNT_W'(1);
            end
          end
          CMD_DELETE: begin
            if (is_empty) begin
              res.status = STS_EMPTY;
            end else begin
              // result comes at the end of the scan
              res.valid  = 1'b0;
              value_nxt  = req_value;
              rd_off_nxt = '0;
              kept_nxt   = '0;
            end
          end
          default: ;
        endcase
        res_length = count_nxt;
      end
    end else begin
      // compaction: read offset i, write survivors back at offset kept
      if (rd_issue) begin
        rd_off_nxt = rd_off_r + CNT_W'(1);
        rd_vld_nxt = 1'b1;
      end
      if (rd_vld_r && (rd_data != value_r)) begin
        wr_en    = 1'b1;
        wr_addr  = wrap_add(head_r, kept_r);
        wr_data  = rd_data;
        kept_nxt = kept_r + CNT_W'(1);
      end
      if (scan_done) begin
        count_nxt   = kept_r;
        res.valid   = 1'b1;
        res.status  = (kept_r == count_r) ? STS_NOT_FOUND : STS_DONE;
        res_removed = count_r - kept_r;
        res_length  = kept_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      rd_off_r <= '0;
      kept_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      rd_off_r <= rd_off_nxt;
      kept_r   <= kept_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CAP_CNT)
  `ASSERT_IMPLIES(a_kept_behind_reads, clk, rst_n, state_r == ST_SCAN, kept_r <= rd_off_r)
  `ASSERT_IMPLIES(a_no_rw_collision, clk, rst_n, wr_en && rd_issue, wr_addr != rd_addr)
  `ASSERT_IMPLIES(a_full_status, clk, rst_n, res.valid && (res.status == STS_FULL), is_full)
  `ASSERT_NEXT(a_scan_ends, clk, rst_n, scan_done, state_r == ST_IDLE)

endmodule

// ===== hw/rtl/bounded_deque_with_delete_by_value_top.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_delete_by_value_top
// double-ended queue in a circular ram with delete of all matching values
// ----------------------------------------------------------------------------
// Each input transaction carries one command (push tail, push head, pop head,
// pop tail, delete value) and gives exactly one result transaction with a
// status, the number of entries removed and the new length. Entries live in a
// single ram of CAPACITY words with a registered read; the head index and
// entry count are flip-flops. Pushes, pops, refused commands and unused codes
// finish in the cycle they are accepted, and the result goes to the output
// register, or to the hold register while the output waits. A delete on a
// non-empty store walks the ram through its one read port, one entry per
// cycle, writing survivors back in order; no command is taken until the scan
// ends. A result register plus one hold register sit on the output, so a
// command is still accepted while one result waits to be taken. Ram contents
// need no clearing after reset: only held entries are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_deque_with_delete_by_value_top #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32,
  localparam int CNT_W      = $clog2(CAPACITY + 1),
  localparam int OUT_RAW    = 2 + 2 * CNT_W,
  localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [2:0] command, [34:3] item_value, rest zero
  input  logic [bdq_pkg::IN_W-1:0] in_tdata,
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [1:0] status, then removed_count (CNT_W bits), then length (CNT_W bits)
  output logic [OUT_W-1:0]     out_tdata
);

  import bdq_pkg::*;

  // command fields
  logic [CMD_W-1:0]         in_command;
  logic [ITEM_W-1:0]        in_item_value;
  logic [VALUE_WIDTH+ITEM_W-1:0] value_ext;
  logic [VALUE_WIDTH-1:0]   in_value;
  logic                     in_accept;

  // engine side
  logic                     eng_ready;
  res_ctl_t                 eng_res;
  logic [CNT_W-1:0]         eng_removed;
  logic [CNT_W-1:0]         eng_length;
  logic [OUT_RAW-1:0]       res_word;

  // output register plus one hold stage
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_RAW-1:0]       out_data_r, out_data_nxt;
  logic                     hold_valid_r, hold_valid_nxt;
  logic [OUT_RAW-1:0]       hold_data_r, hold_data_nxt;
  logic                     out_take;
  logic                     out_free;

  assign in_command    = in_tdata[CMD_W-1:0];
  assign in_item_value = in_tdata[CMD_W+ITEM_W-1:CMD_W];

  // keep the low VALUE_WIDTH bits of the item, zero-extended when wider
  assign value_ext = {VALUE_WIDTH'(0), in_item_value};
  assign in_value  = value_ext[VALUE_WIDTH-1:0];

  // new commands wait only for the engine and a free hold slot
  assign in_tready = eng_ready && !hold_valid_r;
  assign in_accept = in_tvalid && in_tready;

  bdq_engine #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_accept),
    .req_cmd     (in_command),
    .req_value   (in_value),
    .req_ready   (eng_ready),
    .res         (eng_res),
    .res_removed (eng_removed),
    .res_length  (eng_length)
  );

  assign res_word = {eng_length, eng_removed, eng_res.status};

  assign out_take = out_valid_r && out_tready;
  assign out_free = !out_valid_r || out_take;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    hold_valid_nxt = hold_valid_r;
    hold_data_nxt  = hold_data_r;

    if (out_take) begin
      out_valid_nxt = 1'b0;
    end
    // refill from the hold stage first, it is older
    if (out_take && hold_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = hold_data_r;
      hold_valid_nxt = 1'b0;
    end
    // a fresh result only arrives while the hold stage is empty
    if (eng_res.valid) begin
      if (out_free && !hold_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_word;
      end else begin
        hold_valid_nxt = 1'b1;
        hold_data_nxt  = res_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    hold_data_r <= hold_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

  `ASSERT_IMPLIES(a_hold_behind_out, clk, rst_n, hold_valid_r, out_valid_r)
  `ASSERT_IMPLIES(a_no_result_overrun, clk, rst_n, eng_res.valid, !hold_valid_r)
  `ASSERT_NEXT(a_stall_fills_hold, clk, rst_n, eng_res.valid && !out_free, hold_valid_r)

endmodule
